### hw/rtl/bp_site_message_belief_assert.svh
// Assertion macros shared by the belief propagation site modules.
// Depends on nothing; included by the modules that carry checks.
`ifndef BP_SITE_MESSAGE_BELIEF_ASSERT_SVH
`define BP_SITE_MESSAGE_BELIEF_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPSM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// The expression must never be true.
`define BPSM_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### hw/rtl/bpsm_pkg.sv
// Shared types, constants and helper functions for the belief propagation site.
// Depends on nothing; used by every module of the block.
package bpsm_pkg;

   // Sizes of the grid site.
   localparam int MAX_LABELS = 64;
   localparam int NEIGHBORS  = 4;
   localparam int LABEL_W    = $clog2(MAX_LABELS);
   localparam int CNT_W      = $clog2(MAX_LABELS + 1);
   localparam int NB_W       = $clog2(NEIGHBORS);
   localparam int ROWS       = 2 * MAX_LABELS;
   localparam int ROW_W      = $clog2(ROWS);

   // Field widths.
   localparam int MODE_W     = 3;
   localparam int MSG_W      = 16;
   localparam int VALUE_W    = 30;
   localparam int SUM_W      = MSG_W + 2;
   localparam int LAMBDA_W   = 16;
   localparam int TRUNC_W    = 28;
   localparam int OBS_W      = 14;
   localparam int LCOUNT_W   = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 28;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Request mode codes.
   localparam logic [MODE_W-1:0] MODE_WR_PRIOR   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_WR_CURR    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SUM_EXCEPT = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BELIEF     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_BEST       = 3'd4;
   localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd5;
   localparam logic [MODE_W-1:0] MODE_READ       = 3'd6;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_LAMBDA   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRUNC    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OBSERVED = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LCOUNT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PRIOR    = 3'd4;

   // Operation after classification in the front.
   typedef enum logic [2:0] {
      OP_NOP,
      OP_WR_PRIOR,
      OP_WR_CURR,
      OP_SUM_EXCEPT,
      OP_BELIEF,
      OP_BEST,
      OP_CLEAR,
      OP_READ
   } op_kind_type;

   // One classified transaction as held in the queue.
   typedef struct packed {
      op_kind_type           kind;
      logic [NB_W-1:0]       neighbor;
      logic [LABEL_W-1:0]    label;
      logic [MSG_W-1:0]      msg;
   } item_type;

   // Configuration as seen by the back end.
   typedef struct packed {
      logic [LAMBDA_W-1:0]   lambda;
      logic [TRUNC_W-1:0]    trunc;
      logic [OBS_W-1:0]      obs;
      logic [CNT_W-1:0]      count;
      logic                  prior;
   } cfg_type;

   // Number of labels in use, clamped into one up to the label capacity.
   function automatic logic [CNT_W-1:0] eff_count(input logic [LCOUNT_W-1:0] lc);
      logic [CNT_W-1:0] n;
      if (lc == '0) begin
         n = CNT_W'(1);
      end else if (32'(lc) > MAX_LABELS) begin
         n = CNT_W'(MAX_LABELS);
      end else begin
         n = CNT_W'(lc);
      end
      return n;
   endfunction

endpackage

### hw/rtl/bp_site_message_belief.sv
// Top level of the belief propagation site: configuration registers, front end, back end.
// Depends on bpsm_pkg, bpsm_front and bpsm_exec.
//
// One site of a four-neighbor min-sum grid with a truncated quadratic data term.
// Request transactions enter a two-entry queue and are then executed one at a
// time. Writes, clears and no-op requests are answered at dispatch. Prior reads,
// sums and beliefs pass through label issue, with its registered message row
// read, and three datapath stages (square, weighted data term, belief add). The
// best-label search issues one label per cycle through the same pipeline, as the
// message row store has a single read port. Clear resets the per-row valid flags,
// so no sweep of the store is needed.
// Configuration writes are always accepted and must only be made while idle.

module bp_site_message_belief (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // mode[2:0], neighbor[4:3], label[10:5], message_value[26:11], zero fill
   input  logic [bpsm_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // value[29:0], best_label[35:30], zero fill
   output logic [bpsm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [bpsm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpsm_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic [bpsm_pkg::LAMBDA_W-1:0] lambda_ff;
   logic [bpsm_pkg::TRUNC_W-1:0]  trunc_ff;
   logic [bpsm_pkg::OBS_W-1:0]    obs_ff;
   logic [bpsm_pkg::LCOUNT_W-1:0] lcount_ff;
   logic                          prior_ff;
   bpsm_pkg::cfg_type             cfg;
   logic                          q_valid, q_pop;
   bpsm_pkg::item_type            q_item;

   // Configuration registers; writes to unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lambda_ff <= bpsm_pkg::LAMBDA_W'(256);
         trunc_ff  <= bpsm_pkg::TRUNC_W'(65536);
         obs_ff    <= '0;
         lcount_ff <= bpsm_pkg::LCOUNT_W'(64);
         prior_ff  <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            bpsm_pkg::CSR_LAMBDA:   lambda_ff <= csr_data[bpsm_pkg::LAMBDA_W-1:0];
            bpsm_pkg::CSR_TRUNC:    trunc_ff  <= csr_data[bpsm_pkg::TRUNC_W-1:0];
            bpsm_pkg::CSR_OBSERVED: obs_ff    <= csr_data[bpsm_pkg::OBS_W-1:0];
            bpsm_pkg::CSR_LCOUNT:   lcount_ff <= csr_data[bpsm_pkg::LCOUNT_W-1:0];
            bpsm_pkg::CSR_PRIOR:    prior_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.lambda = lambda_ff;
      cfg.trunc  = trunc_ff;
      cfg.obs    = obs_ff;
      cfg.count  = bpsm_pkg::eff_count(lcount_ff);
      cfg.prior  = prior_ff;
   end

   bpsm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .label_count (cfg.count),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   bpsm_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### hw/rtl/bpsm_front.sv
// Front end of the belief propagation site: accepts and classifies transactions.
// Depends on bpsm_pkg and the assertion macro header.
`include "bp_site_message_belief_assert.svh"

module bpsm_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // mode[2:0], neighbor[4:3], label[10:5], message_value[26:11], zero fill
   input  logic [bpsm_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [bpsm_pkg::CNT_W-1:0]     label_count,
   output logic                           q_valid,
   output bpsm_pkg::item_type             q_item,
   input  logic                           q_pop
);

   localparam int PTR_W = (bpsm_pkg::QUEUE_DEPTH > 1) ? $clog2(bpsm_pkg::QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(bpsm_pkg::QUEUE_DEPTH + 1);

   logic [bpsm_pkg::MODE_W-1:0]  req_mode;
   logic [bpsm_pkg::LABEL_W-1:0] req_label;
   logic                         in_range;
   bpsm_pkg::item_type           new_item;
   logic                         push;

   bpsm_pkg::item_type entry_ff [bpsm_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   // Field extraction.
   assign req_mode  = req_tdata[2:0];
   assign req_label = req_tdata[10:5];
   assign in_range  = bpsm_pkg::CNT_W'(req_label) < label_count;

   // Classify the transaction; out-of-range labels make no-ops of all but searches and clears.
   always_comb begin
      new_item.neighbor = req_tdata[4:3];
      new_item.label    = req_label;
      new_item.msg      = req_tdata[26:11];
      unique case (req_mode)
         bpsm_pkg::MODE_WR_PRIOR:
            new_item.kind = in_range ? bpsm_pkg::OP_WR_PRIOR : bpsm_pkg::OP_NOP;
         bpsm_pkg::MODE_WR_CURR:
            new_item.kind = in_range ? bpsm_pkg::OP_WR_CURR : bpsm_pkg::OP_NOP;
         bpsm_pkg::MODE_SUM_EXCEPT:
            new_item.kind = in_range ? bpsm_pkg::OP_SUM_EXCEPT : bpsm_pkg::OP_NOP;
         bpsm_pkg::MODE_BELIEF:
            new_item.kind = in_range ? bpsm_pkg::OP_BELIEF : bpsm_pkg::OP_NOP;
         bpsm_pkg::MODE_BEST:  new_item.kind = bpsm_pkg::OP_BEST;
         bpsm_pkg::MODE_CLEAR: new_item.kind = bpsm_pkg::OP_CLEAR;
         bpsm_pkg::MODE_READ:
            new_item.kind = in_range ? bpsm_pkg::OP_READ : bpsm_pkg::OP_NOP;
         default:              new_item.kind = bpsm_pkg::OP_NOP;
      endcase
   end

   // Queue handshake.
   assign req_tready = count_ff != QCNT_W'(bpsm_pkg::QUEUE_DEPTH);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = count_ff != '0;
   assign q_item     = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(bpsm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(bpsm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

   `BPSM_ASSERT_IMPLY(a_pop_not_empty, clock, reset, q_pop, count_ff != '0, "pop from empty queue")
   `BPSM_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > QCNT_W'(bpsm_pkg::QUEUE_DEPTH), "queue overfilled")
   `BPSM_ASSERT_IMPLY(a_ptr_empty, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff, "pointers disagree on empty queue")

endmodule

### hw/rtl/bpsm_exec.sv
// Back end of the belief propagation site: message store, belief datapath, result register.
// Depends on bpsm_pkg and the assertion macro header.
`include "bp_site_message_belief_assert.svh"

module bpsm_exec (
   input  logic                            clock,
   input  logic                            reset,
   input  bpsm_pkg::cfg_type               cfg,
   input  logic                            q_valid,
   input  bpsm_pkg::item_type              q_item,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // value[29:0], best_label[35:30], zero fill
   output logic [bpsm_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int LANES_W = bpsm_pkg::NEIGHBORS * bpsm_pkg::MSG_W;
   localparam int ABS_W   = bpsm_pkg::OBS_W;
   localparam int PROD_W  = bpsm_pkg::LAMBDA_W + bpsm_pkg::TRUNC_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;
   bpsm_pkg::item_type op_ff;
   logic [bpsm_pkg::LABEL_W-1:0] scan_lab_ff, scan_lab_in;

   logic out_free, start, immediate, issue, issue_last, fin, rsp_load;

   // Message store: one row per bank and label, one lane per neighbor.
   logic [LANES_W-1:0]            msg_mem_ff [bpsm_pkg::ROWS];
   logic [LANES_W-1:0]            rdata_ff;
   logic [bpsm_pkg::ROWS-1:0]     row_valid_ff;
   logic                          wr_en, clear;
   logic [bpsm_pkg::ROW_W-1:0]    wr_row, rd_row;
   logic [bpsm_pkg::NEIGHBORS-1:0] lane_we;

   // Datapath stages.
   logic                          p1_valid_ff, p1_last_ff, p1_first_ff, p1_row_valid_ff;
   logic [ABS_W-1:0]              p1_absd_ff;
   logic [bpsm_pkg::LABEL_W-1:0]  p1_label_ff;
   logic                          p2_valid_ff, p2_last_ff, p2_first_ff;
   logic [bpsm_pkg::TRUNC_W-1:0]  p2_sq_ff;
   logic signed [bpsm_pkg::SUM_W-1:0] p2_sum4_ff, p2_aux_ff;
   logic [bpsm_pkg::LABEL_W-1:0]  p2_label_ff;
   logic                          p3_valid_ff, p3_last_ff, p3_first_ff;
   logic [bpsm_pkg::TRUNC_W-1:0]  p3_dterm_ff;
   logic signed [bpsm_pkg::SUM_W-1:0] p3_sum4_ff, p3_aux_ff;
   logic [bpsm_pkg::LABEL_W-1:0]  p3_label_ff;

   logic signed [ABS_W:0]         diff;
   logic [ABS_W-1:0]              absd;
   logic signed [bpsm_pkg::SUM_W-1:0] sum4, aux;
   logic [bpsm_pkg::TRUNC_W-1:0]  capped;
   logic [PROD_W-1:0]             prod;
   logic signed [bpsm_pkg::VALUE_W-1:0] belief, cand_val, best_val_ff, rsp_value;
   logic [bpsm_pkg::LABEL_W-1:0]  cand_lab, best_lab_ff, rsp_best;
   logic                          take;

   logic                          rsp_valid_ff;
   logic [bpsm_pkg::VALUE_W-1:0]  rsp_value_ff;
   logic [bpsm_pkg::LABEL_W-1:0]  rsp_best_ff;

   // Dispatch from the queue when idle and the result register is free.
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign start     = (state_ff == ST_IDLE) && q_valid && out_free;
   assign q_pop     = start;
   assign immediate = (q_item.kind == bpsm_pkg::OP_NOP) || (q_item.kind == bpsm_pkg::OP_CLEAR)
                   || (q_item.kind == bpsm_pkg::OP_WR_PRIOR)
                   || (q_item.kind == bpsm_pkg::OP_WR_CURR);

   // Label issue: one label a cycle; the best-label search walks all labels in use.
   assign issue      = state_ff == ST_SCAN;
   assign issue_last = (op_ff.kind != bpsm_pkg::OP_BEST)
                    || (bpsm_pkg::CNT_W'(scan_lab_ff) == cfg.count - bpsm_pkg::CNT_W'(1));
   assign fin        = p3_valid_ff && p3_last_ff;

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      scan_lab_in = scan_lab_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && !immediate) begin
               state_in    = ST_SCAN;
               scan_lab_in = (q_item.kind == bpsm_pkg::OP_BEST) ? '0 : q_item.label;
            end
         end
         ST_SCAN: begin
            if (issue_last) begin
               state_in = ST_DRAIN;
            end else begin
               scan_lab_in = scan_lab_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (fin) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_lab_ff <= scan_lab_in;
      if (start) begin
         op_ff <= q_item;
      end
   end

   // Store writes; a row never written since clear reads as zero on all lanes.
   assign wr_en  = start && ((q_item.kind == bpsm_pkg::OP_WR_PRIOR)
                          || (q_item.kind == bpsm_pkg::OP_WR_CURR));
   assign clear  = start && (q_item.kind == bpsm_pkg::OP_CLEAR);
   assign wr_row = {cfg.prior ^ (q_item.kind == bpsm_pkg::OP_WR_CURR), q_item.label};
   assign rd_row = {cfg.prior, scan_lab_ff};

   always_comb begin
      for (int n = 0; n < bpsm_pkg::NEIGHBORS; n++) begin
         lane_we[n] = !row_valid_ff[wr_row] || (q_item.neighbor == bpsm_pkg::NB_W'(n));
      end
   end

   always_ff @(posedge clock) begin
      for (int n = 0; n < bpsm_pkg::NEIGHBORS; n++) begin
         if (wr_en && lane_we[n]) begin
            msg_mem_ff[wr_row][n*bpsm_pkg::MSG_W +: bpsm_pkg::MSG_W] <=
               (q_item.neighbor == bpsm_pkg::NB_W'(n)) ? q_item.msg : '0;
         end
      end
      rdata_ff <= msg_mem_ff[rd_row];
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_row] <= 1'b1;
      end
   end

   // Issue stage: label distance to the observation.
   assign diff = $signed({1'b0, scan_lab_ff, 8'h00}) - $signed({1'b0, cfg.obs});
   assign absd = diff[ABS_W] ? ABS_W'(-diff) : diff[ABS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= issue;
         p2_valid_ff <= p1_valid_ff;
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_last_ff      <= issue_last;
      p1_first_ff     <= scan_lab_ff == '0;
      p1_row_valid_ff <= row_valid_ff[rd_row];
      p1_absd_ff      <= absd;
      p1_label_ff     <= scan_lab_ff;
   end

   // Stage one: message sums and the squared distance.
   always_comb begin : s1_sum
      logic [bpsm_pkg::MSG_W-1:0]        lane;
      logic signed [bpsm_pkg::SUM_W-1:0] lane_ext;
      logic signed [bpsm_pkg::SUM_W-1:0] sel;
      sum4 = '0;
      sel  = '0;
      for (int n = 0; n < bpsm_pkg::NEIGHBORS; n++) begin
         lane     = p1_row_valid_ff ? rdata_ff[n*bpsm_pkg::MSG_W +: bpsm_pkg::MSG_W] : '0;
         lane_ext = $signed({{(bpsm_pkg::SUM_W-bpsm_pkg::MSG_W){lane[bpsm_pkg::MSG_W-1]}},
                             lane});
         sum4     = sum4 + lane_ext;
         if (op_ff.neighbor == bpsm_pkg::NB_W'(n)) begin
            sel = lane_ext;
         end
      end
      aux = (op_ff.kind == bpsm_pkg::OP_SUM_EXCEPT) ? sum4 - sel : sel;
   end

   always_ff @(posedge clock) begin
      p2_last_ff  <= p1_last_ff;
      p2_first_ff <= p1_first_ff;
      p2_sq_ff    <= bpsm_pkg::TRUNC_W'(p1_absd_ff) * bpsm_pkg::TRUNC_W'(p1_absd_ff);
      p2_sum4_ff  <= sum4;
      p2_aux_ff   <= aux;
      p2_label_ff <= p1_label_ff;
   end

   // Stage two: truncated quadratic data term.
   assign capped = (p2_sq_ff < cfg.trunc) ? p2_sq_ff : cfg.trunc;
   assign prod   = PROD_W'(cfg.lambda) * PROD_W'(capped);

   always_ff @(posedge clock) begin
      p3_last_ff  <= p2_last_ff;
      p3_first_ff <= p2_first_ff;
      p3_dterm_ff <= prod[PROD_W-1:16];
      p3_sum4_ff  <= p2_sum4_ff;
      p3_aux_ff   <= p2_aux_ff;
      p3_label_ff <= p2_label_ff;
   end

   // Stage three: belief and running minimum; a later label wins only when strictly lower.
   assign belief = $signed(
      {{(bpsm_pkg::VALUE_W-bpsm_pkg::TRUNC_W){1'b0}}, p3_dterm_ff}
      + {{(bpsm_pkg::VALUE_W-bpsm_pkg::SUM_W-8){p3_sum4_ff[bpsm_pkg::SUM_W-1]}},
         p3_sum4_ff, 8'h00});
   assign take     = p3_first_ff || (belief < best_val_ff);
   assign cand_val = take ? belief : best_val_ff;
   assign cand_lab = take ? p3_label_ff : best_lab_ff;

   always_ff @(posedge clock) begin
      if (p3_valid_ff) begin
         best_val_ff <= cand_val;
         best_lab_ff <= cand_lab;
      end
   end

   // Result selection.
   always_comb begin
      rsp_value = '0;
      rsp_best  = '0;
      if (fin) begin
         unique case (op_ff.kind)
            bpsm_pkg::OP_BELIEF: rsp_value = belief;
            bpsm_pkg::OP_BEST: begin
               rsp_value = cand_val;
               rsp_best  = cand_lab;
            end
            bpsm_pkg::OP_SUM_EXCEPT, bpsm_pkg::OP_READ:
               rsp_value = $signed({{(bpsm_pkg::VALUE_W-bpsm_pkg::SUM_W)
                                     {p3_aux_ff[bpsm_pkg::SUM_W-1]}}, p3_aux_ff});
            default: rsp_value = '0;
         endcase
      end
   end

   // Output register.
   assign rsp_load = (start && immediate) || fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff <= rsp_value;
         rsp_best_ff  <= rsp_best;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(bpsm_pkg::RSP_DATA_W-bpsm_pkg::VALUE_W-bpsm_pkg::LABEL_W){1'b0}},
                        rsp_best_ff, rsp_value_ff};

   `BPSM_ASSERT_NEVER(a_rsp_overrun, clock, reset, rsp_load && rsp_valid_ff && !rsp_tready, "result register overwritten")
   `BPSM_ASSERT_IMPLY(a_idle_drained, clock, reset, state_ff == ST_IDLE, !(p1_valid_ff || p2_valid_ff || p3_valid_ff), "datapath busy while idle")
   `BPSM_ASSERT_IMPLY(a_one_last, clock, reset, p1_valid_ff || p2_valid_ff || p3_valid_ff, $onehot0({p1_valid_ff && p1_last_ff, p2_valid_ff && p2_last_ff, p3_valid_ff && p3_last_ff}), "more than one final label in flight")
   `BPSM_ASSERT_NEXT(a_fin_idle, clock, reset, fin, state_ff == ST_IDLE, "sequencer not idle after result")

endmodule

### test/tb_bp_site_message_belief.sv
// Self-checking testbench for the belief propagation site bp_site_message_belief.
// Depends on bpsm_pkg and the block's RTL; predicts every response and compares it.
`timescale 1ns / 100ps

module tb_bp_site_message_belief;

   // Mode 7 has no operation behind it; the site must answer it with zeros.
   localparam logic [bpsm_pkg::MODE_W-1:0] MODE_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 80;
   localparam int RSP_HOLD_CYCLES = 200;

   typedef struct {
      logic [bpsm_pkg::MODE_W-1:0]         mode;
      logic [bpsm_pkg::NB_W-1:0]           neighbor;
      logic [bpsm_pkg::LABEL_W-1:0]        label;
      logic signed [bpsm_pkg::MSG_W-1:0]   msg;
   } site_req_type;

   typedef struct {
      logic [bpsm_pkg::VALUE_W-1:0]        value;
      logic [bpsm_pkg::LABEL_W-1:0]        best;
   } site_rsp_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [bpsm_pkg::REQ_DATA_W-1:0]      req_tdata = '0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [bpsm_pkg::RSP_DATA_W-1:0]      rsp_tdata;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [bpsm_pkg::CSR_IDX_W-1:0]       csr_index = '0;
   logic [bpsm_pkg::CSR_DATA_W-1:0]      csr_data = '0;

   // Predicted site state: both message banks and the register values.
   logic signed [bpsm_pkg::MSG_W-1:0]
      msg_bank [2][bpsm_pkg::NEIGHBORS][bpsm_pkg::MAX_LABELS] = '{default: '0};
   logic [bpsm_pkg::LAMBDA_W-1:0]        lambda_cfg = 16'd256;
   logic [bpsm_pkg::TRUNC_W-1:0]         trunc_cfg = 28'd65536;
   logic [bpsm_pkg::OBS_W-1:0]           obs_cfg = '0;
   logic [bpsm_pkg::LCOUNT_W-1:0]        count_cfg = 7'd64;
   logic                                 prior_cfg = 1'b0;

   site_rsp_type                         site_answers_due [$];

   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit long_hold_req = 1'b0;
   int error_count = 0;
   int cycle_count = 0;
   int items_sent = 0;
   int searches_sent = 0;
   int clears_sent = 0;
   int csr_writes = 0;

   bp_site_message_belief u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Run limit in case the site stops answering.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("ERROR at %0t: %s", $time, what);
   endtask

   // Labels in use, clamped into one up to the label capacity.
   function automatic int active_labels();
      int n;
      n = int'(count_cfg);
      if (n < 1) n = 1;
      if (n > bpsm_pkg::MAX_LABELS) n = bpsm_pkg::MAX_LABELS;
      return n;
   endfunction

   // Truncated quadratic data term in Q.8.
   function automatic longint label_cost(input int lab);
      longint offset;
      longint sq;
      longint capped;
      offset = longint'(lab) * 256 - longint'(obs_cfg);
      sq = offset * offset;
      capped = (sq < longint'(trunc_cfg)) ? sq : longint'(trunc_cfg);
      return (longint'(lambda_cfg) * capped) >>> 16;
   endfunction

   function automatic longint label_belief(input int lab);
      longint msg_sum;
      msg_sum = 0;
      for (int n = 0; n < bpsm_pkg::NEIGHBORS; n++) begin
         msg_sum += longint'(msg_bank[prior_cfg][n][lab]);
      end
      return label_cost(lab) + msg_sum * 256;
   endfunction

   // Applies one request to the predicted state and returns its response.
   function automatic site_rsp_type site_model_step(input site_req_type r);
      site_rsp_type ans;
      longint acc;
      longint cand;
      int best;
      bit in_rng;
      acc = 0;
      best = 0;
      in_rng = int'(r.label) < active_labels();
      case (r.mode)
         bpsm_pkg::MODE_WR_PRIOR: begin
            if (in_rng) msg_bank[prior_cfg][r.neighbor][r.label] = r.msg;
         end
         bpsm_pkg::MODE_WR_CURR: begin
            if (in_rng) msg_bank[!prior_cfg][r.neighbor][r.label] = r.msg;
         end
         bpsm_pkg::MODE_SUM_EXCEPT: begin
            if (in_rng) begin
               for (int n = 0; n < bpsm_pkg::NEIGHBORS; n++) begin
                  if (n != int'(r.neighbor)) begin
                     acc += longint'(msg_bank[prior_cfg][n][r.label]);
                  end
               end
            end
         end
         bpsm_pkg::MODE_BELIEF: begin
            if (in_rng) acc = label_belief(int'(r.label));
         end
         bpsm_pkg::MODE_BEST: begin
            // Only a strictly lower belief displaces the current winner.
            acc = label_belief(0);
            for (int l = 1; l < active_labels(); l++) begin
               cand = label_belief(l);
               if (cand < acc) begin
                  acc = cand;
                  best = l;
               end
            end
         end
         bpsm_pkg::MODE_CLEAR: begin
            msg_bank = '{default: '0};
         end
         bpsm_pkg::MODE_READ: begin
            if (in_rng) acc = longint'(msg_bank[prior_cfg][r.neighbor][r.label]);
         end
         default: begin
         end
      endcase
      ans.value = acc[bpsm_pkg::VALUE_W-1:0];
      ans.best = bpsm_pkg::LABEL_W'(best);
      return ans;
   endfunction

   // Receiver: checks each response transaction and throttles rsp_tready.
   always @(posedge clock) begin : rsp_side
      site_rsp_type due;
      int hold_left;
      bit hold_started;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (site_answers_due.size() == 0) begin
            report_mismatch($sformatf("response 0x%h with nothing outstanding", rsp_tdata));
         end else begin
            due = site_answers_due.pop_front();
            if (rsp_tdata[bpsm_pkg::VALUE_W-1:0] !== due.value) begin
               report_mismatch($sformatf("value 0x%h, expected 0x%h",
                                         rsp_tdata[bpsm_pkg::VALUE_W-1:0], due.value));
            end
            if (rsp_tdata[bpsm_pkg::VALUE_W +: bpsm_pkg::LABEL_W] !== due.best) begin
               report_mismatch($sformatf("best_label %0d, expected %0d",
                                         rsp_tdata[bpsm_pkg::VALUE_W +: bpsm_pkg::LABEL_W],
                                         due.best));
            end
         end
      end
      // A long hold is taken once on request; otherwise ready is random.
      if (long_hold_req && !hold_started) begin
         hold_started = 1'b1;
         hold_left = RSP_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Offers one request transaction and predicts its response once accepted.
   task automatic send_request(input site_req_type r);
      site_rsp_type ans;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, r.msg, r.label, r.neighbor, r.mode};
      do @(posedge clock); while (!req_tready);
      ans = site_model_step(r);
      site_answers_due = {site_answers_due, ans};
      items_sent++;
      if (r.mode == bpsm_pkg::MODE_BEST) searches_sent++;
      if (r.mode == bpsm_pkg::MODE_CLEAR) clears_sent++;
   endtask

   task automatic send_fields(input logic [bpsm_pkg::MODE_W-1:0] mode, input int nb,
                              input int lab, input int msg);
      site_req_type r;
      r.mode = mode;
      r.neighbor = bpsm_pkg::NB_W'(nb);
      r.label = bpsm_pkg::LABEL_W'(lab);
      r.msg = bpsm_pkg::MSG_W'(msg);
      send_request(r);
   endtask

   // Stops offering requests and waits until the site has drained.
   task automatic settle_site();
      req_tvalid <= 1'b0;
      while (site_answers_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [bpsm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bpsm_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
      case (idx)
         bpsm_pkg::CSR_LAMBDA:   lambda_cfg = data[bpsm_pkg::LAMBDA_W-1:0];
         bpsm_pkg::CSR_TRUNC:    trunc_cfg = data[bpsm_pkg::TRUNC_W-1:0];
         bpsm_pkg::CSR_OBSERVED: obs_cfg = data[bpsm_pkg::OBS_W-1:0];
         bpsm_pkg::CSR_LCOUNT:   count_cfg = data[bpsm_pkg::LCOUNT_W-1:0];
         bpsm_pkg::CSR_PRIOR:    prior_cfg = data[0];
         default: begin
         end
      endcase
   endtask

   task automatic write_all_csrs(input int lambda, input int trunc, input int obs, input int cnt,
                                 input int prior);
      settle_site();
      write_csr(bpsm_pkg::CSR_LAMBDA, bpsm_pkg::CSR_DATA_W'(lambda));
      write_csr(bpsm_pkg::CSR_TRUNC, bpsm_pkg::CSR_DATA_W'(trunc));
      write_csr(bpsm_pkg::CSR_OBSERVED, bpsm_pkg::CSR_DATA_W'(obs));
      write_csr(bpsm_pkg::CSR_LCOUNT, bpsm_pkg::CSR_DATA_W'(cnt));
      write_csr(bpsm_pkg::CSR_PRIOR, bpsm_pkg::CSR_DATA_W'(prior));
   endtask

   function automatic site_req_type random_request();
      site_req_type r;
      int pick;
      pick = $urandom_range(99);
      if (pick < 22) r.mode = bpsm_pkg::MODE_WR_PRIOR;
      else if (pick < 34) r.mode = bpsm_pkg::MODE_WR_CURR;
      else if (pick < 46) r.mode = bpsm_pkg::MODE_SUM_EXCEPT;
      else if (pick < 60) r.mode = bpsm_pkg::MODE_BELIEF;
      else if (pick < 68) r.mode = bpsm_pkg::MODE_BEST;
      else if (pick < 71) r.mode = bpsm_pkg::MODE_CLEAR;
      else if (pick < 74) r.mode = MODE_UNUSED;
      else r.mode = bpsm_pkg::MODE_READ;
      r.neighbor = bpsm_pkg::NB_W'($urandom_range(bpsm_pkg::NEIGHBORS - 1));
      // Most labels fall inside the active range, the rest anywhere up to the label capacity.
      if ($urandom_range(99) < 85) begin
         r.label = bpsm_pkg::LABEL_W'($urandom_range(active_labels() - 1));
      end else begin
         r.label = bpsm_pkg::LABEL_W'($urandom_range(bpsm_pkg::MAX_LABELS - 1));
      end
      case ($urandom_range(9))
         0: r.msg = 16'sh8000;
         1: r.msg = 16'sh7fff;
         default: r.msg = bpsm_pkg::MSG_W'($urandom());
      endcase
      return r;
   endfunction

   // One neighbor update round on a label, followed by a query on it.
   task automatic send_message_burst();
      site_req_type r;
      int lab;
      lab = $urandom_range(active_labels() - 1);
      for (int n = 0; n < bpsm_pkg::NEIGHBORS; n++) begin
         r.mode = ($urandom_range(99) < 75) ? bpsm_pkg::MODE_WR_PRIOR : bpsm_pkg::MODE_WR_CURR;
         r.neighbor = bpsm_pkg::NB_W'(n);
         r.label = bpsm_pkg::LABEL_W'(lab);
         r.msg = bpsm_pkg::MSG_W'($urandom());
         send_request(r);
      end
      case ($urandom_range(2))
         0: r.mode = bpsm_pkg::MODE_SUM_EXCEPT;
         1: r.mode = bpsm_pkg::MODE_BELIEF;
         default: r.mode = bpsm_pkg::MODE_READ;
      endcase
      r.neighbor = bpsm_pkg::NB_W'($urandom_range(bpsm_pkg::NEIGHBORS - 1));
      send_request(r);
   endtask

   task automatic randomize_csrs();
      int cnt;
      int trunc;
      cnt = ($urandom_range(99) < 70) ? $urandom_range(1, bpsm_pkg::MAX_LABELS)
                                      : $urandom_range(0, 127);
      trunc = ($urandom_range(1)) ? $urandom_range(0, 1 << 22) : ($urandom() & 32'h0fff_ffff);
      write_all_csrs($urandom_range(0, 65535), trunc, $urandom_range(0, 16383), cnt,
                     $urandom_range(1));
   endtask

   // Reset contents: zero messages and the default data term.
   task automatic test_reset_defaults();
      send_fields(bpsm_pkg::MODE_READ, 3, 63, 0);
      send_fields(bpsm_pkg::MODE_BEST, 0, 0, 0);
   endtask

   // Message writes at the extremes, reads, sums, a belief, the prior bank swap, an unused mode and a clear.
   task automatic test_message_access();
      send_fields(bpsm_pkg::MODE_WR_PRIOR, 0, 0, -32768);
      send_fields(bpsm_pkg::MODE_WR_PRIOR, 1, 0, 32767);
      send_fields(bpsm_pkg::MODE_WR_PRIOR, 2, 0, -1);
      send_fields(bpsm_pkg::MODE_WR_PRIOR, 3, 0, 1);
      send_fields(bpsm_pkg::MODE_SUM_EXCEPT, 0, 0, 0);
      send_fields(bpsm_pkg::MODE_SUM_EXCEPT, 3, 0, 0);
      send_fields(bpsm_pkg::MODE_READ, 1, 0, 0);
      send_fields(bpsm_pkg::MODE_BELIEF, 0, 0, 0);
      send_fields(bpsm_pkg::MODE_WR_CURR, 2, 63, 23130);
      settle_site();
      write_csr(bpsm_pkg::CSR_PRIOR, 28'd1);
      send_fields(bpsm_pkg::MODE_READ, 2, 63, 0);
      send_fields(bpsm_pkg::MODE_SUM_EXCEPT, 1, 63, 0);
      settle_site();
      write_csr(bpsm_pkg::CSR_PRIOR, 28'd0);
      send_fields(MODE_UNUSED, 3, 63, 65535);
      send_fields(bpsm_pkg::MODE_CLEAR, 0, 0, 0);
      send_fields(bpsm_pkg::MODE_READ, 0, 0, 0);
   endtask

   // A zero count clamps to one label, a count above capacity to all of them.
   task automatic test_label_range();
      settle_site();
      write_csr(bpsm_pkg::CSR_LCOUNT, 28'd0);
      send_fields(bpsm_pkg::MODE_WR_PRIOR, 0, 1, 1234);
      send_fields(bpsm_pkg::MODE_READ, 0, 1, 0);
      send_fields(bpsm_pkg::MODE_BEST, 0, 0, 0);
      settle_site();
      write_csr(bpsm_pkg::CSR_LCOUNT, 28'd127);
      send_fields(bpsm_pkg::MODE_READ, 0, 63, 0);
      settle_site();
      write_csr(bpsm_pkg::CSR_LCOUNT, 28'd10);
      send_fields(bpsm_pkg::MODE_WR_PRIOR, 2, 10, -5);
      send_fields(bpsm_pkg::MODE_BEST, 0, 0, 0);
   endtask

   // Data term at its extremes and a tie between two labels.
   task automatic test_data_term();
      write_all_csrs(65535, 268435455, 16383, 64, 0);
      send_fields(bpsm_pkg::MODE_BELIEF, 0, 0, 0);
      send_fields(bpsm_pkg::MODE_BELIEF, 0, 63, 0);
      send_fields(bpsm_pkg::MODE_BEST, 0, 0, 0);
      write_all_csrs(0, 0, 0, 64, 1);
      send_fields(bpsm_pkg::MODE_BELIEF, 0, 40, 0);
      // Observed label 2.5 is equally far from labels 2 and 3.
      write_all_csrs(256, 268435455, 640, 64, 0);
      send_fields(bpsm_pkg::MODE_BEST, 0, 0, 0);
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      settle_site();
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      long_hold_req = 1'b1;
      for (int i = 0; i < 40; i++) begin
         send_request(random_request());
      end
      settle_site();
   endtask

   // Random traffic in three idling phases, four register settings each.
   task automatic test_random_traffic();
      int sent_at_start;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 27;
               rsp_idle_pct = 45;
            end
            1: begin
               send_idle_pct = 45;
               rsp_idle_pct = 27;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (int seg = 0; seg < 4; seg++) begin
            if (phase == 0 && seg == 0) write_all_csrs(65535, 268435455, 16383, 64, 1);
            else if (phase == 1 && seg == 0) write_all_csrs(0, 0, 0, 0, 0);
            else randomize_csrs();
            sent_at_start = items_sent;
            while (items_sent - sent_at_start < 65) begin
               if ($urandom_range(99) < 30) send_message_burst();
               else send_request(random_request());
            end
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 27;
      rsp_idle_pct = 45;
      test_reset_defaults();
      test_message_access();
      test_label_range();
      test_data_term();
      test_backpressure();
      test_random_traffic();
      settle_site();
      $display("Sent %0d requests, %0d of them label searches and %0d clears,",
               items_sent, searches_sent, clears_sent);
      $display("across %0d register writes and a long response stall.", csr_writes);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
